/* design/vsync_play_position_predictor_core_defines.svh */
// Assertion macros for the play position predictor
`ifndef VSYNC_PLAY_POSITION_PREDICTOR_CORE_DEFINES_SVH
`define VSYNC_PLAY_POSITION_PREDICTOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define VPP_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("vpp assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define VPP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("vpp assertion failed");

`endif

/* design/vpp_pkg.sv */
// Types, constants and a shared function of the play position predictor
package vpp_pkg;

  localparam int POS_W   = 48;
  localparam int FRAC_W  = 16;
  localparam int RATE_W  = 24;
  localparam int STEP_W  = 32;
  localparam int US_W    = 20;
  localparam int VSYNC_W = 32;
  localparam int FLAG_W  = 4;
  localparam int STAT_W  = 2;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_BUFFER  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_INTERVAL = CFG_IDX_W'(1);
  localparam logic [US_W-1:0] SYNC_RESET = US_W'(16667);

  localparam logic [STAT_W-1:0] ST_IN_RANGE = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_CLAMP_LO = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_CLAMP_HI = STAT_W'(2);

  localparam int FLG_LOOP     = 0;
  localparam int FLG_IN_HOLD  = 1;
  localparam int FLG_OUT_HOLD = 2;
  localparam int FLG_SLIP     = 3;

  localparam int TW     = VSYNC_W + 2;
  localparam int OFF_W  = 24;
  localparam int PROD_W = STEP_W + OFF_W;
  localparam int PMAG_W = PROD_W - 1;
  localparam int SLO_W  = 28;
  localparam int SHI_W  = PMAG_W - SLO_W;
  localparam int LO_PW  = SLO_W + RATE_W;
  localparam int HI_PW  = SHI_W + RATE_W;
  localparam int MUL_W  = PMAG_W + RATE_W;
  localparam int MAG_W  = MUL_W - FRAC_W;
  localparam int SA_W   = ((MAG_W > POS_W) ? MAG_W : POS_W) + 1;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef struct packed {
    logic signed [POS_W-1:0]   play_pos;
    logic signed [RATE_W-1:0]  play_rate;
    logic signed [STEP_W-1:0]  position_step;
    logic signed [POS_W-1:0]   slip_pos;
    logic signed [RATE_W-1:0]  slip_rate;
    logic signed [POS_W-1:0]   loop_start;
    logic signed [POS_W-1:0]   loop_end;
    logic [FLAG_W-1:0]         mode_flags;
    logic [US_W-1:0]           callback_to_dac_us;
    logic signed [VSYNC_W-1:0] ref_to_vsync_us;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] play_pos_out;
    logic signed [POS_W-1:0] slip_pos_out;
    logic [STAT_W-1:0]       offset_status;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  play_pos;
    logic signed [RATE_W-1:0] play_rate;
    logic signed [POS_W-1:0]  slip_pos;
    logic signed [RATE_W-1:0] slip_rate;
    logic signed [POS_W-1:0]  loop_start;
    logic signed [POS_W-1:0]  loop_end;
    logic [FLAG_W-1:0]        mode_flags;
    logic [STAT_W-1:0]        status;
    logic                     s_neg;
    logic                     s_zero;
  } scale_ctx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] interp;
    logic signed [POS_W-1:0] slip_moved;
    logic signed [POS_W-1:0] loop_start;
    logic signed [POS_W-1:0] loop_end;
    logic [STAT_W-1:0]       status;
    logic                    slip_run;
    logic                    back;
    logic                    fwd;
  } wrap_ctx_t;

  function automatic logic signed [POS_W-1:0] sat_add(
    input logic signed [POS_W-1:0] a,
    input logic                    neg,
    input logic [MAG_W-1:0]        mag
  );
    logic [SA_W-1:0] ae;
    logic [SA_W-1:0] me;
    logic [SA_W-1:0] room;
    logic signed [POS_W-1:0] res;
    ae = SA_W'(a);
    me = SA_W'(mag);
    if (!neg) begin
      room = SA_W'(POS_MAX) - ae;
      res  = (me >= room) ? POS_MAX : $signed(POS_W'(ae + me));
    end else begin
      room = ae - SA_W'(POS_MIN);
      res  = (me >= room) ? POS_MIN : $signed(POS_W'(ae - me));
    end
    return res;
  endfunction

endpackage

/* design/vpp_div_cell.sv */
// One restoring-division cell: one quotient bit per stage
module vpp_div_cell #(
  parameter int NW  = vpp_pkg::POS_W,
  parameter int DW  = vpp_pkg::POS_W,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_v,
  output logic           up_rdy,
  input  logic [NW-1:0]  up_num,
  input  logic [DW-1:0]  up_rem,
  input  logic [DW-1:0]  up_div,
  input  logic [SBW-1:0] up_sb,
  output logic           dn_v,
  input  logic           dn_rdy,
  output logic [NW-1:0]  dn_num,
  output logic [DW-1:0]  dn_rem,
  output logic [DW-1:0]  dn_div,
  output logic [SBW-1:0] dn_sb
);

  logic           v_r;
  logic [NW-1:0]  num_r, num_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  div_r;
  logic [SBW-1:0] sb_r;
  logic [DW:0]    trial;
  logic           ge;

  always_comb begin
    trial   = {up_rem, up_num[NW-1]};
    ge      = (trial >= {1'b0, up_div});
    rem_nxt = ge ? DW'(trial - {1'b0, up_div}) : trial[DW-1:0];
    num_nxt = {up_num[NW-2:0], ge};
  end

  assign up_rdy = !v_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_rdy) begin
      v_r <= up_v;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      div_r <= up_div;
      sb_r  <= up_sb;
    end
  end

  assign dn_v   = v_r;
  assign dn_num = num_r;
  assign dn_rem = rem_r;
  assign dn_div = div_r;
  assign dn_sb  = sb_r;

endmodule

/* design/vpp_div_chain.sv */
// Row of division cells giving quotient and remainder, one item per cycle unless out_ready stalls it
module vpp_div_chain #(
  parameter int NW  = vpp_pkg::POS_W,
  parameter int DW  = vpp_pkg::POS_W,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [NW-1:0]  in_num,
  input  logic [DW-1:0]  in_div,
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [NW-1:0]  out_quo,
  output logic [DW-1:0]  out_rem,
  output logic [DW-1:0]  out_div,
  output logic [SBW-1:0] out_sb
);

  logic           v   [0:NW];
  logic           rdy [0:NW];
  logic [NW-1:0]  num [0:NW];
  logic [DW-1:0]  rem [0:NW];
  logic [DW-1:0]  dv  [0:NW];
  logic [SBW-1:0] sb  [0:NW];

  assign v[0]    = in_valid;
  assign num[0]  = in_num;
  assign rem[0]  = '0;
  assign dv[0]   = in_div;
  assign sb[0]   = in_sb;
  assign in_ready = rdy[0];
  assign rdy[NW] = out_ready;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    vpp_div_cell #(.NW(NW), .DW(DW), .SBW(SBW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .up_v   (v[k]),
      .up_rdy (rdy[k]),
      .up_num (num[k]),
      .up_rem (rem[k]),
      .up_div (dv[k]),
      .up_sb  (sb[k]),
      .dn_v   (v[k+1]),
      .dn_rdy (rdy[k+1]),
      .dn_num (num[k+1]),
      .dn_rem (rem[k+1]),
      .dn_div (dv[k+1]),
      .dn_sb  (sb[k+1])
    );
  end

  assign out_valid = v[NW];
  assign out_quo   = num[NW];
  assign out_rem   = rem[NW];
  assign out_div   = dv[NW];
  assign out_sb    = sb[NW];

endmodule

/* design/vsync_play_position_predictor_core.sv */
// Play position predictor top level: clamp, scale, move, loop wrap
// Path: an item passes, in order, through the input register, 1 product stage,
//   55 cells of the offset-scaling divider, 5 multiply, saturate and loop-check stages,
//   48 cells of the loop-remainder divider and 2 finishing stages, holding under back-pressure.
// Throughput: one item per cycle while out_ready is high; every stage holds only while the next is full.
// Reset: clears all valid bits, audio buffer to 0, sync interval to 16667;
//   no clearing pass.
`include "vsync_play_position_predictor_core_defines.svh"
module vsync_play_position_predictor_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  vpp_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output vpp_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vpp_pkg::US_W-1:0]      cfg_data
);
  import vpp_pkg::*;

  logic [US_W-1:0] abuf_r;
  logic [US_W-1:0] sync_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abuf_r <= '0;
      sync_r <= SYNC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_AUDIO_BUFFER) begin
        abuf_r <= cfg_data;
      end else if (cfg_index == REG_SYNC_INTERVAL) begin
        sync_r <= cfg_data;
      end
    end
  end

  // front stage: offset and clamp
  logic                     s0_v_r, s0_rdy;
  scale_ctx_t               s0_ctx_r, s0_ctx_nxt;
  logic signed [OFF_W-1:0]  s0_off_r, s0_off_nxt;
  logic signed [STEP_W-1:0] s0_step_r;
  logic signed [TW-1:0]     off_raw, lo_lim, hi_lim, off_c;

  always_comb begin
    off_raw = $signed(TW'(in_data.ref_to_vsync_us))
              - $signed(TW'(in_data.callback_to_dac_us));
    lo_lim  = -$signed(TW'(in_data.callback_to_dac_us));
    hi_lim  = $signed(TW'(abuf_r) + (TW'(sync_r) << 1));
    s0_ctx_nxt.play_pos   = in_data.play_pos;
    s0_ctx_nxt.play_rate  = in_data.play_rate;
    s0_ctx_nxt.slip_pos   = in_data.slip_pos;
    s0_ctx_nxt.slip_rate  = in_data.slip_rate;
    s0_ctx_nxt.loop_start = in_data.loop_start;
    s0_ctx_nxt.loop_end   = in_data.loop_end;
    s0_ctx_nxt.mode_flags = in_data.mode_flags;
    s0_ctx_nxt.s_zero     = (abuf_r == '0);
    off_c = off_raw;
    s0_ctx_nxt.status = ST_IN_RANGE;
    if (abuf_r == '0) begin
      off_c = '0;
    end else if (off_raw < lo_lim) begin
      off_c = lo_lim;
      s0_ctx_nxt.status = ST_CLAMP_LO;
    end else if (off_raw > hi_lim) begin
      off_c = hi_lim;
      s0_ctx_nxt.status = ST_CLAMP_HI;
    end
    s0_ctx_nxt.s_neg = in_data.position_step[STEP_W-1] ^ off_c[TW-1];
    s0_off_nxt = OFF_W'(off_c);
  end

  // product stage
  logic                     s1_v_r, s1_rdy;
  scale_ctx_t               s1_ctx_r;
  logic signed [PROD_W-1:0] s1_prod_r;
  logic [PROD_W-1:0]        s1_pabs;
  logic                     d1_in_ready;

  assign in_ready = s0_rdy;
  assign s0_rdy   = !s0_v_r || s1_rdy;
  assign s1_rdy   = !s1_v_r || d1_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      if (s0_rdy) s0_v_r <= in_valid;
      if (s1_rdy) s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy) begin
      s0_ctx_r  <= s0_ctx_nxt;
      s0_off_r  <= s0_off_nxt;
      s0_step_r <= in_data.position_step;
    end
    if (s1_rdy) begin
      s1_prod_r <= s0_step_r * s0_off_r;
      s1_ctx_r  <= s0_ctx_r;
    end
  end

  assign s1_pabs = s1_prod_r[PROD_W-1] ? PROD_W'(-s1_prod_r) : PROD_W'(s1_prod_r);

  // scaling divider
  logic              d1_v, s3_rdy;
  logic [PMAG_W-1:0] d1_quo;
  logic [US_W-1:0]   d1_rem, d1_div;
  scale_ctx_t        d1_ctx;

  vpp_div_chain #(.NW(PMAG_W), .DW(US_W), .SBW($bits(scale_ctx_t))) u_scale_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_ready  (d1_in_ready),
    .in_num    (s1_pabs[PMAG_W-1:0]),
    .in_div    (abuf_r),
    .in_sb     (s1_ctx_r),
    .out_valid (d1_v),
    .out_ready (s3_rdy),
    .out_quo   (d1_quo),
    .out_rem   (d1_rem),
    .out_div   (d1_div),
    .out_sb    (d1_ctx)
  );

  // multiply stages, low then high partial products
  logic              s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;
  logic              s4_rdy, s5_rdy, s6_rdy, s7_rdy, d2_in_ready;
  scale_ctx_t        s3_ctx_r, s4_ctx_r, s5_ctx_r, s6_ctx_r;
  logic [PMAG_W-1:0] ms;
  logic [RATE_W-1:0] pra, sra;
  logic [SHI_W-1:0]  s3_mshi_r;
  logic [RATE_W-1:0] s3_pra_r, s3_sra_r;
  logic [LO_PW-1:0]  s3_pl_r, s3_sl_r, s4_pl_r, s4_sl_r;
  logic [HI_PW-1:0]  s4_ph_r, s4_sh_r;
  logic              s3_pneg_r, s3_sneg_r, s4_pneg_r, s4_sneg_r, s5_pneg_r, s5_sneg_r;
  logic [MUL_W-1:0]  pfull, sfull;
  logic [MAG_W-1:0]  s5_pmag_r, s5_smag_r;
  logic signed [POS_W-1:0] s6_interp_r, s6_slip_r;

  always_comb begin
    ms  = d1_ctx.s_zero ? '0 : d1_quo;
    pra = d1_ctx.play_rate[RATE_W-1] ? RATE_W'(-d1_ctx.play_rate) : RATE_W'(d1_ctx.play_rate);
    sra = d1_ctx.slip_rate[RATE_W-1] ? RATE_W'(-d1_ctx.slip_rate) : RATE_W'(d1_ctx.slip_rate);
    pfull = MUL_W'(s4_pl_r) + (MUL_W'(s4_ph_r) << SLO_W);
    sfull = MUL_W'(s4_sl_r) + (MUL_W'(s4_sh_r) << SLO_W);
  end

  assign s3_rdy = !s3_v_r || s4_rdy;
  assign s4_rdy = !s4_v_r || s5_rdy;
  assign s5_rdy = !s5_v_r || s6_rdy;
  assign s6_rdy = !s6_v_r || s7_rdy;
  assign s7_rdy = !s7_v_r || d2_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else begin
      if (s3_rdy) s3_v_r <= d1_v;
      if (s4_rdy) s4_v_r <= s3_v_r;
      if (s5_rdy) s5_v_r <= s4_v_r;
      if (s6_rdy) s6_v_r <= s5_v_r;
      if (s7_rdy) s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_ctx_r  <= d1_ctx;
      s3_mshi_r <= ms[PMAG_W-1:SLO_W];
      s3_pra_r  <= pra;
      s3_sra_r  <= sra;
      s3_pl_r   <= LO_PW'(ms[SLO_W-1:0]) * LO_PW'(pra);
      s3_sl_r   <= LO_PW'(ms[SLO_W-1:0]) * LO_PW'(sra);
      s3_pneg_r <= d1_ctx.s_neg ^ d1_ctx.play_rate[RATE_W-1];
      s3_sneg_r <= d1_ctx.s_neg ^ d1_ctx.slip_rate[RATE_W-1];
    end
    if (s4_rdy) begin
      s4_ctx_r  <= s3_ctx_r;
      s4_pl_r   <= s3_pl_r;
      s4_sl_r   <= s3_sl_r;
      s4_ph_r   <= HI_PW'(s3_mshi_r) * HI_PW'(s3_pra_r);
      s4_sh_r   <= HI_PW'(s3_mshi_r) * HI_PW'(s3_sra_r);
      s4_pneg_r <= s3_pneg_r;
      s4_sneg_r <= s3_sneg_r;
    end
    if (s5_rdy) begin
      s5_ctx_r  <= s4_ctx_r;
      s5_pmag_r <= pfull[MUL_W-1:FRAC_W];
      s5_smag_r <= sfull[MUL_W-1:FRAC_W];
      s5_pneg_r <= s4_pneg_r;
      s5_sneg_r <= s4_sneg_r;
    end
    if (s6_rdy) begin
      s6_ctx_r    <= s5_ctx_r;
      s6_interp_r <= sat_add(s5_ctx_r.play_pos, s5_pneg_r, s5_pmag_r);
      s6_slip_r   <= sat_add(s5_ctx_r.slip_pos, s5_sneg_r, s5_smag_r);
    end
  end

  // loop check and remainder setup
  wrap_ctx_t        s7_ctx_r, s7_ctx_nxt;
  logic [POS_W-1:0] s7_x_r, s7_x_nxt, s7_size_r, s7_size_nxt;
  logic             loop_on;

  always_comb begin
    loop_on = s6_ctx_r.mode_flags[FLG_LOOP] && (s6_ctx_r.loop_end > s6_ctx_r.loop_start);
    s7_ctx_nxt.interp     = s6_interp_r;
    s7_ctx_nxt.slip_moved = s6_slip_r;
    s7_ctx_nxt.loop_start = s6_ctx_r.loop_start;
    s7_ctx_nxt.loop_end   = s6_ctx_r.loop_end;
    s7_ctx_nxt.status     = s6_ctx_r.status;
    s7_ctx_nxt.slip_run   = s6_ctx_r.mode_flags[FLG_SLIP];
    s7_ctx_nxt.back = loop_on && (s6_ctx_r.play_rate < 0)
                      && (s6_interp_r < s6_ctx_r.loop_start)
                      && (s6_ctx_r.play_pos >= s6_ctx_r.loop_start)
                      && !s6_ctx_r.mode_flags[FLG_IN_HOLD];
    s7_ctx_nxt.fwd  = loop_on && (s6_ctx_r.play_rate > 0)
                      && (s6_interp_r > s6_ctx_r.loop_end)
                      && (s6_ctx_r.play_pos <= s6_ctx_r.loop_end)
                      && !s6_ctx_r.mode_flags[FLG_OUT_HOLD];
    s7_x_nxt = s7_ctx_nxt.back ? POS_W'(s6_ctx_r.loop_start - s6_interp_r)
                               : POS_W'(s6_interp_r - s6_ctx_r.loop_end);
    s7_size_nxt = POS_W'(s6_ctx_r.loop_end - s6_ctx_r.loop_start);
  end

  always_ff @(posedge clk) begin
    if (s7_rdy) begin
      s7_ctx_r  <= s7_ctx_nxt;
      s7_x_r    <= s7_x_nxt;
      s7_size_r <= s7_size_nxt;
    end
  end

  // loop remainder divider
  logic             d2_v, s8_rdy;
  logic [POS_W-1:0] d2_quo, d2_rem, d2_div;
  wrap_ctx_t        d2_ctx;

  vpp_div_chain #(.NW(POS_W), .DW(POS_W), .SBW($bits(wrap_ctx_t))) u_wrap_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s7_v_r),
    .in_ready  (d2_in_ready),
    .in_num    (s7_x_r),
    .in_div    (s7_size_r),
    .in_sb     (s7_ctx_r),
    .out_valid (d2_v),
    .out_ready (s8_rdy),
    .out_quo   (d2_quo),
    .out_rem   (d2_rem),
    .out_div   (d2_div),
    .out_sb    (d2_ctx)
  );

  // round to nearest, ties to even
  logic             s8_v_r, s9_rdy;
  wrap_ctx_t        s8_ctx_r;
  logic             s8_near_r, near;
  logic [POS_W-1:0] s8_mag_r, rest;

  always_comb begin
    rest = d2_div - d2_rem;
    near = (d2_rem > rest) || ((d2_rem == rest) && d2_quo[0]);
  end

  assign s8_rdy = !s8_v_r || s9_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (s8_rdy) begin
      s8_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s8_rdy) begin
      s8_ctx_r  <= d2_ctx;
      s8_near_r <= near;
      s8_mag_r  <= near ? rest : d2_rem;
    end
  end

  // output register
  logic                    out_valid_r;
  out_item_t               out_data_r, out_nxt;
  logic signed [POS_W-1:0] play_fin;

  always_comb begin
    if (s8_ctx_r.back) begin
      play_fin = sat_add(s8_ctx_r.loop_end, !s8_near_r, MAG_W'(s8_mag_r));
    end else if (s8_ctx_r.fwd) begin
      play_fin = sat_add(s8_ctx_r.loop_start, s8_near_r, MAG_W'(s8_mag_r));
    end else begin
      play_fin = s8_ctx_r.interp;
    end
    out_nxt.play_pos_out  = play_fin;
    out_nxt.slip_pos_out  = s8_ctx_r.slip_run ? s8_ctx_r.slip_moved : play_fin;
    out_nxt.offset_status = s8_ctx_r.status;
  end

  assign s9_rdy = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s9_rdy) begin
      out_valid_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s9_rdy) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `VPP_ASSERT_IMPL(a_status_code, out_valid_r, (out_data_r.offset_status == ST_IN_RANGE) || (out_data_r.offset_status == ST_CLAMP_LO) || (out_data_r.offset_status == ST_CLAMP_HI))
  `VPP_ASSERT_IMPL(a_zero_scale, s5_v_r && s5_ctx_r.s_zero, (s5_pmag_r == '0) && (s5_smag_r == '0))
  `VPP_ASSERT_IMPL(a_wrap_excl, s7_v_r, !(s7_ctx_r.back && s7_ctx_r.fwd))
  `VPP_ASSERT_IMPL(a_rem_below, d2_v && (d2_ctx.back || d2_ctx.fwd), d2_rem < d2_div)
  `VPP_ASSERT_NEXT(a_stage_hold, s6_v_r && !s7_rdy, s6_v_r)

endmodule

/* test/vpp_checker.sv */
// Checker for the play position predictor: predicts each query and compares results
module vpp_checker
  import vpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [US_W-1:0]      cfg_data,
  output int                   fail_count,
  output int                   pending
);

  logic [US_W-1:0] buffer_us;
  logic [US_W-1:0] interval_us;
  out_item_t       expected_q[$];

  initial fail_count = 0;
  assign pending = expected_q.size();

  function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = POS_MAX;
    lo = POS_MIN;
    if (v > hi) return POS_MAX;
    if (v < lo) return POS_MIN;
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [127:0] advance_pos(input logic signed [POS_W-1:0] pos,
                                                     input longint s,
                                                     input logic signed [RATE_W-1:0] rate);
    logic signed [127:0] sw;
    logic signed [127:0] rw;
    logic signed [127:0] prod;
    logic signed [127:0] mag;
    sw = s;
    rw = rate;
    prod = sw * rw;
    mag = (prod < 0) ? -prod : prod;
    mag = mag >> FRAC_W;
    return clamp_pos(pos + ((prod < 0) ? -mag : mag));
  endfunction

  // remainder with quotient rounded to nearest, ties to even
  function automatic logic signed [127:0] nearest_rem(input longint unsigned x,
                                                      input longint unsigned y);
    longint unsigned q;
    longint unsigned r;
    longint unsigned rest;
    logic signed [127:0] res;
    q = x / y;
    r = x % y;
    rest = y - r;
    if (r > rest || (r == rest && q[0])) res = -$signed({64'd0, rest});
    else res = $signed({64'd0, r});
    return res;
  endfunction

  function automatic out_item_t predict_vsync(input in_item_t it);
    longint s;
    longint off;
    longint hi_lim;
    longint lo_lim;
    logic [STAT_W-1:0] st;
    logic signed [127:0] interp;
    logic signed [127:0] play;
    logic signed [127:0] ls;
    logic signed [127:0] le;
    logic signed [127:0] d;
    longint unsigned size;
    out_item_t r;
    s = 0;
    st = ST_IN_RANGE;
    if (buffer_us != 0) begin
      hi_lim = longint'(buffer_us) + 2 * longint'(interval_us);
      lo_lim = -longint'(it.callback_to_dac_us);
      off = longint'(it.ref_to_vsync_us) - longint'(it.callback_to_dac_us);
      if (off < lo_lim) begin
        off = lo_lim;
        st = ST_CLAMP_LO;
      end else if (off > hi_lim) begin
        off = hi_lim;
        st = ST_CLAMP_HI;
      end
      s = (longint'(it.position_step) * off) / longint'(buffer_us);
    end
    interp = advance_pos(it.play_pos, s, it.play_rate);
    play = it.play_pos;
    ls = it.loop_start;
    le = it.loop_end;
    if (it.mode_flags[FLG_LOOP] && le > ls) begin
      size = 64'(le - ls);
      if (it.play_rate < 0 && interp < ls && play >= ls && !it.mode_flags[FLG_IN_HOLD]) begin
        d = nearest_rem(64'(ls - interp), size);
        interp = clamp_pos(le - d);
      end
      if (it.play_rate > 0 && interp > le && play <= le && !it.mode_flags[FLG_OUT_HOLD]) begin
        d = nearest_rem(64'(interp - le), size);
        interp = clamp_pos(ls + d);
      end
    end
    r.play_pos_out = interp[POS_W-1:0];
    if (it.mode_flags[FLG_SLIP])
      r.slip_pos_out = POS_W'(advance_pos(it.slip_pos, s, it.slip_rate));
    else r.slip_pos_out = interp[POS_W-1:0];
    r.offset_status = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [POS_W-1:0] got,
                                 input logic [POS_W-1:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      buffer_us <= '0;
      interval_us <= SYNC_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_AUDIO_BUFFER) buffer_us <= cfg_data;
        else if (cfg_index == REG_SYNC_INTERVAL) interval_us <= cfg_data;
      end
      if (in_valid && in_ready) expected_q.push_back(predict_vsync(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transfer", out_data.play_pos_out, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.play_pos_out !== want.play_pos_out)
            report_mismatch("play_pos_out", out_data.play_pos_out, want.play_pos_out);
          if (out_data.slip_pos_out !== want.slip_pos_out)
            report_mismatch("slip_pos_out", out_data.slip_pos_out, want.slip_pos_out);
          if (out_data.offset_status !== want.offset_status)
            report_mismatch("offset_status", POS_W'(out_data.offset_status),
                            POS_W'(want.offset_status));
        end
      end
    end
  end

endmodule

/* test/tb_top.sv */
// Testbench top for the play position predictor: stimulus, flow control and verdict
module tb_top;
  import vpp_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(2);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [US_W-1:0]      cfg_data = '0;
  int                   fail_count;
  int                   pending;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          cycles = 0;
  int unsigned buf_now = 0;
  int unsigned sync_now = 16667;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  vsync_play_position_predictor_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  vpp_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= 700;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= US_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_AUDIO_BUFFER) buf_now = val;
    else if (idx == REG_SYNC_INTERVAL) sync_now = val;
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_query(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic settle_input;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'({$urandom, $urandom});
  endfunction

  function automatic in_item_t rand_query();
    in_item_t it;
    int unsigned sel;
    longint win_hi;
    longint offs;
    sel = $urandom_range(99);
    it.play_pos = rand_pos();
    it.play_rate = RATE_W'($urandom);
    it.position_step = $urandom;
    it.slip_pos = rand_pos();
    it.slip_rate = RATE_W'($urandom);
    it.loop_start = rand_pos();
    it.loop_end = rand_pos();
    it.mode_flags = FLAG_W'($urandom);
    it.callback_to_dac_us = US_W'($urandom_range(1000000));
    it.ref_to_vsync_us = $urandom;
    if (sel < 65) begin
      if (sel < 20) it.play_pos = $signed(POS_W'($urandom)) - $signed(POS_W'($urandom));
      it.loop_start = it.play_pos - POS_W'($urandom_range(1 << 22));
      it.loop_end = it.play_pos + POS_W'($urandom_range(1 << 22));
      it.mode_flags[FLG_LOOP] = ($urandom_range(9) != 0);
      it.position_step = $signed(32'($urandom_range(1 << 24))) - 32'sd8388608;
      if ($urandom_range(1)) it.play_rate = $signed(RATE_W'($urandom_range(1 << 20))) - 24'sd524288;
      it.callback_to_dac_us = US_W'($urandom_range(30000));
      win_hi = longint'(buf_now) + 2 * longint'(sync_now);
      offs = longint'($urandom_range(32'(win_hi + 4000))) - 2000;
      if ($urandom_range(3) == 0) offs = -longint'($urandom_range(it.callback_to_dac_us + 100));
      it.ref_to_vsync_us = 32'(offs + longint'(it.callback_to_dac_us));
    end else if (sel < 75) begin
      it.play_pos = $urandom_range(1) ? POS_MAX - POS_W'($urandom_range(1 << 20))
                                      : POS_MIN + POS_W'($urandom_range(1 << 20));
      it.loop_end = POS_MAX;
      it.loop_start = POS_MIN;
    end
    return it;
  endfunction

  function automatic in_item_t directed_query(input int k);
    in_item_t it;
    it.play_pos = 48'sd1 <<< 24;
    it.play_rate = 24'sd65536;
    it.position_step = 32'sd1 <<< 20;
    it.slip_pos = 48'sd3 <<< 22;
    it.slip_rate = -24'sd65536;
    it.loop_start = 48'sd1 <<< 23;
    it.loop_end = (48'sd1 <<< 24) + 48'sd100000;
    it.mode_flags = 4'(1 << FLG_LOOP);
    it.callback_to_dac_us = 20'd5000;
    it.ref_to_vsync_us = 32'sd25000;
    case (k)
      0: begin
        it.play_pos = POS_MAX;
        it.play_rate = 24'sh7fffff;
        it.position_step = 32'sh7fffffff;
        it.mode_flags = '0;
      end
      1: begin
        it.play_pos = POS_MIN;
        it.play_rate = 24'sh7fffff;
        it.position_step = 32'sh80000000;
        it.mode_flags = 4'(1 << FLG_SLIP);
        it.slip_pos = POS_MIN;
        it.slip_rate = 24'sh800000;
      end
      2: it.ref_to_vsync_us = 32'sh80000000;
      3: it.ref_to_vsync_us = 32'sh7fffffff;
      4: it.callback_to_dac_us = 20'd1000000;
      5: it.callback_to_dac_us = '0;
      6: it.play_rate = '0;
      7: it.loop_end = it.loop_start;
      8: begin
        it.play_rate = -24'sd131072;
        it.play_pos = it.loop_start + 48'sd10;
      end
      9: begin
        it.play_rate = -24'sd131072;
        it.play_pos = it.loop_start + 48'sd10;
        it.mode_flags = 4'((1 << FLG_LOOP) | (1 << FLG_IN_HOLD));
      end
      10: it.mode_flags = 4'((1 << FLG_LOOP) | (1 << FLG_OUT_HOLD));
      11: it.mode_flags = 4'hf;
      12: begin
        it.loop_start = POS_MIN;
        it.loop_end = POS_MAX;
        it.play_pos = POS_MAX - 48'sd5;
      end
      13: begin
        it.loop_start = it.play_pos - 48'sd2;
        it.loop_end = it.play_pos + 48'sd2;
      end
      14: it.position_step = '0;
      default: begin
        it.mode_flags = 4'(k);
        it.ref_to_vsync_us = 32'(k * 3000 - 10000);
      end
    endcase
    return it;
  endfunction

  task automatic run_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_query(rand_query());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < 8; k++) send_query(directed_query(k));
    settle_input();
    drain();
    write_reg(REG_AUDIO_BUFFER, 20000);
    write_reg(REG_UNUSED, 777);
    for (int k = 0; k < 18; k++) send_query(directed_query(k));
    settle_input();
    drain();

    run_phase(200, 0, 0);
    settle_input();
    drain();
    write_reg(REG_AUDIO_BUFFER, 1000000);
    write_reg(REG_SYNC_INTERVAL, 1000000);
    run_phase(180, 81, 0);
    settle_input();
    drain();
    write_reg(REG_AUDIO_BUFFER, 1);
    write_reg(REG_SYNC_INTERVAL, 0);
    run_phase(180, 0, 81);
    settle_input();
    drain();
    write_reg(REG_AUDIO_BUFFER, 11520);
    write_reg(REG_SYNC_INTERVAL, 16667);
    hold_req <= 1'b1;
    run_phase(300, 0, 0);
    settle_input();
    drain();
    write_reg(REG_AUDIO_BUFFER, 0);
    run_phase(60, 18, 18);
    settle_input();
    drain();
    write_reg(REG_AUDIO_BUFFER, 4096);
    write_reg(REG_SYNC_INTERVAL, 8333);
    run_phase(180, 18, 18);
    settle_input();

    drain();
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/vpp_pkg.sv
design/vpp_div_cell.sv
design/vpp_div_chain.sv
design/vsync_play_position_predictor_core.sv
test/vpp_checker.sv
test/tb_top.sv
